>>> rtl/kts_pkg.sv
// Shared types, constants and register codes for the tracking filter step.
// No dependencies; used by all modules under rtl.
package kts_pkg;

   localparam int LanesDefault = 4;
   localparam int DataWidth    = 32;
   localparam int RegWidth     = 31;
   localparam int CountWidth   = 16;
   localparam int GainWidth    = 17;
   localparam int CsrIdxWidth  = 2;

   localparam logic [RegWidth-1:0] QReset    = 31'd6554;
   localparam logic [RegWidth-1:0] RReset    = 31'd6554;
   localparam logic [RegWidth-1:0] PInitReset = 31'd655360;

   localparam logic [CsrIdxWidth-1:0] RegProcessNoise     = 2'd0;
   localparam logic [CsrIdxWidth-1:0] RegMeasurementNoise = 2'd1;
   localparam logic [CsrIdxWidth-1:0] RegInitialCov       = 2'd2;

   // Saturate a 34-bit signed value into 32 bits.
   function automatic logic signed [DataWidth-1:0] sat32(input logic signed [33:0] v);
      logic signed [33:0] hi;
      logic signed [33:0] lo;
      hi = 34'sd2147483647;
      lo = -34'sd2147483648;
      if (v > hi) begin
         sat32 = 32'sh7fffffff;
      end else if (v < lo) begin
         sat32 = 32'sh80000000;
      end else begin
         sat32 = v[DataWidth-1:0];
      end
   endfunction

endpackage

>>> rtl/kts_gain_div.sv
// Serial restoring divider: gain = floor(p * 65536 / s), one quotient bit per cycle.
// Depends on kts_pkg.
module kts_gain_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [kts_pkg::DataWidth-1:0]     p_val,
   input  logic [kts_pkg::DataWidth-1:0]     s_val,
   output logic                              done,
   output logic [kts_pkg::GainWidth-1:0]     gain
);
   localparam int NumWidth = kts_pkg::DataWidth + 16;

   logic [NumWidth-1:0]             num_ff, num_in;
   logic [kts_pkg::DataWidth:0]     rem_ff, rem_in;
   logic [kts_pkg::DataWidth-1:0]   div_ff, div_in;
   logic [NumWidth-1:0]             quo_ff, quo_in;
   logic [5:0]                      cnt_ff, cnt_in;
   logic                            busy_ff, busy_in;
   logic                            done_ff, done_in;
   logic [kts_pkg::DataWidth:0]     trial;

   // Load the operands on start; while busy, shift in one numerator bit and try the subtraction.
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[kts_pkg::DataWidth-1:0], num_ff[NumWidth-1]};
      if (start) begin
         num_in  = {p_val, 16'd0};
         rem_in  = '0;
         div_in  = s_val;
         quo_in  = '0;
         cnt_in  = 6'(NumWidth);
         busy_in = (s_val != '0);
         done_in = (s_val == '0);
      end else if (busy_ff) begin
         num_in = num_ff << 1;
         if (trial >= {1'b0, div_ff}) begin
            rem_in = trial - {1'b0, div_ff};
            quo_in = {quo_ff[NumWidth-2:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[NumWidth-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   // Quotient never exceeds 65536 since p <= s.
   assign done = done_ff;
   assign gain = quo_ff[kts_pkg::GainWidth-1:0];
endmodule

>>> rtl/kts_lane.sv
// One filter lane: prediction, residual and gain correction for one component.
// Depends on kts_pkg.
module kts_lane (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                predict,
   input  logic                                mult,
   input  logic                                correct,
   input  logic signed [kts_pkg::DataWidth-1:0] meas,
   input  logic [kts_pkg::GainWidth-1:0]        gain,
   output logic signed [kts_pkg::DataWidth-1:0] pred,
   output logic signed [kts_pkg::DataWidth-1:0] est
);
   logic signed [kts_pkg::DataWidth-1:0] est_ff, est_in;
   logic signed [kts_pkg::DataWidth-1:0] res_ff, res_in;
   logic signed [kts_pkg::DataWidth-1:0] pred_ff, pred_in;
   logic signed [49:0]                   prod_ff, prod_in;
   logic signed [kts_pkg::DataWidth-1:0] p_next;
   logic signed [49:0]                   rnd;
   logic signed [33:0]                   corr;

   // Predict, multiply, then round and add the correction.
   always_comb begin
      p_next  = kts_pkg::sat32(34'(est_ff) + 34'(res_ff));
      est_in  = est_ff;
      res_in  = res_ff;
      pred_in = pred_ff;
      prod_in = $signed({1'b0, gain}) * 50'(res_ff);
      rnd     = prod_ff + 50'sd32768;
      corr    = 34'(rnd >>> 16);
      if (predict) begin
         est_in  = p_next;
         pred_in = p_next;
         res_in  = kts_pkg::sat32(34'(meas) - 34'(p_next));
      end else if (correct) begin
         est_in = kts_pkg::sat32(34'(est_ff) + corr);
      end
      if (!mult) begin
         prod_in = prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_ff <= '0;
         res_ff <= '0;
      end else begin
         est_ff <= est_in;
         res_ff <= res_in;
      end
      pred_ff <= pred_in;
      prod_ff <= prod_in;
   end

   assign pred = pred_ff;
   assign est  = est_ff;
endmodule

>>> rtl/kts_cov.sv
// Shared covariance path: p + q, s = p + r, and the gain*gain*s reduction.
// Depends on kts_pkg.
module kts_cov (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            load,
   input  logic [kts_pkg::RegWidth-1:0]    load_val,
   input  logic                            add_q,
   input  logic                            sq,
   input  logic                            mul_s,
   input  logic                            reduce,
   input  logic [kts_pkg::RegWidth-1:0]    q_val,
   input  logic [kts_pkg::RegWidth-1:0]    r_val,
   input  logic [kts_pkg::GainWidth-1:0]   gain,
   output logic [kts_pkg::DataWidth-1:0]   p_out,
   output logic [kts_pkg::DataWidth-1:0]   s_out
);
   logic [kts_pkg::DataWidth-1:0] p_ff, p_in;
   logic [kts_pkg::DataWidth-1:0] s_ff, s_in;
   logic [33:0]                   g2_ff, g2_in;
   logic [65:0]                   red_ff, red_in;
   logic [32:0]                   sum_q;
   logic [32:0]                   sum_r;
   logic [33:0]                   red_val;

   always_comb begin
      sum_q  = 33'(p_ff) + 33'(q_val);
      sum_r  = 33'(p_ff) + 33'(r_val);
      p_in   = p_ff;
      s_in   = s_ff;
      g2_in  = sq ? 34'(gain) * 34'(gain) : g2_ff;
      red_in = mul_s ? 66'(g2_ff) * 66'(s_ff) : red_ff;
      red_val = 34'((red_ff + 66'h80000000) >> 32);
      // Load p on a register write, saturate sums, then clamp the reduction at zero.
      if (load) begin
         p_in = 32'(load_val);
      end else if (add_q) begin
         p_in = sum_q[32] ? '1 : sum_q[31:0];
      end else if (reduce) begin
         p_in = (red_val >= 34'(p_ff)) ? '0 : p_ff - red_val[31:0];
      end
      if (add_q) begin
         s_in = '0;
      end else if (sq) begin
         s_in = sum_r[32] ? '1 : sum_r[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_ff <= 32'(kts_pkg::PInitReset);
      end else begin
         p_ff <= p_in;
      end
      s_ff   <= s_in;
      g2_ff  <= g2_in;
      red_ff <= red_in;
   end

   // s is formed combinationally, in the cycle after p + q, from the updated p.
   assign p_out = p_ff;
   assign s_out = sum_r[32] ? '1 : sum_r[31:0];
endmodule

>>> rtl/kalman_tracker_step.sv
// Top level of the tracking filter step: sequencer, lanes, divider, covariance.
// Depends on kts_pkg, kts_lane, kts_gain_div, kts_cov.
//
//  channel | ports                    | direction
//  req     | req_valid/ready, meas_*  | in
//  rsp     | rsp_valid/ready, pred_*, est_*, step_count | out
//  csr     | csr_valid/ready, index, data | in
//
// Items do not overlap: after an input transfer the sequencer steps through prediction,
// forming s, the serial gain divider (48 quotient bits, then its done flag), products,
// correction, covariance reduction and output; then comes the result transfer, and only
// then the next input transfer. While the receiver holds rsp_ready low, the next item waits.
// Reset sets estimates and residuals to zero and covariance to 10.0.
// The result holds in an output register; the next item is taken once it is sent.
module kalman_tracker_step #(
   parameter int LANES = kts_pkg::LanesDefault
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic signed [kts_pkg::DataWidth-1:0] req_meas_lane [LANES],
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [kts_pkg::DataWidth-1:0] rsp_pred_lane [LANES],
   output logic signed [kts_pkg::DataWidth-1:0] rsp_est_lane [LANES],
   output logic [kts_pkg::CountWidth-1:0]       rsp_step_count,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [kts_pkg::CsrIdxWidth-1:0]      csr_index,
   input  logic [kts_pkg::DataWidth-1:0]        csr_data
);
   localparam logic [3:0] StIdle   = 4'd0;
   localparam logic [3:0] StPred   = 4'd1;
   localparam logic [3:0] StS      = 4'd2;
   localparam logic [3:0] StDiv    = 4'd3;
   localparam logic [3:0] StMul    = 4'd4;
   localparam logic [3:0] StMulS   = 4'd5;
   localparam logic [3:0] StUpd    = 4'd6;
   localparam logic [3:0] StOut    = 4'd7;

   logic [3:0]                      state_ff, state_in;
   logic [kts_pkg::RegWidth-1:0]    q_ff, r_ff;
   logic [kts_pkg::CountWidth-1:0]  cnt_ff;
   logic                            out_valid_ff;
   logic signed [kts_pkg::DataWidth-1:0] meas_ff [LANES];
   logic signed [kts_pkg::DataWidth-1:0] pred_w [LANES];
   logic signed [kts_pkg::DataWidth-1:0] est_w [LANES];
   logic [kts_pkg::GainWidth-1:0]   gain_w, gain_ff;
   logic                            div_done;
   logic [kts_pkg::DataWidth-1:0]   p_w, s_w;
   logic                            cfg_wr;

   assign req_ready = (state_ff == StIdle) && !out_valid_ff;
   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;

   // Advance the step sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         StIdle: if (req_valid && req_ready) state_in = StPred;
         StPred: state_in = StS;
         StS:    state_in = StDiv;
         StDiv:  if (div_done) state_in = StMul;
         StMul:  state_in = StMulS;
         StMulS: state_in = StUpd;
         StUpd:  state_in = StOut;
         StOut:  state_in = StIdle;
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= StIdle;
         q_ff         <= kts_pkg::QReset;
         r_ff         <= kts_pkg::RReset;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg_wr && csr_index == kts_pkg::RegProcessNoise) q_ff <= csr_data[30:0];
         if (cfg_wr && csr_index == kts_pkg::RegMeasurementNoise) r_ff <= csr_data[30:0];
         if (state_ff == StOut) begin
            cnt_ff       <= cnt_ff + 16'd1;
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (req_valid && req_ready) meas_ff <= req_meas_lane;
      if (div_done) gain_ff <= gain_w;
   end

   // Lanes run side by side.
   for (genvar i = 0; i < LANES; i++) begin : g_lane
      kts_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .predict (state_ff == StPred),
         .mult    (state_ff == StMul),
         .correct (state_ff == StMulS),
         .meas    (meas_ff[i]),
         .gain    (gain_ff),
         .pred    (pred_w[i]),
         .est     (est_w[i])
      );
   end

   kts_gain_div u_div (
      .clock (clock),
      .reset (reset),
      .start (state_ff == StS),
      .p_val (p_w),
      .s_val (s_w),
      .done  (div_done),
      .gain  (gain_w)
   );

   kts_cov u_cov (
      .clock    (clock),
      .reset    (reset),
      .load     (cfg_wr && csr_index == kts_pkg::RegInitialCov),
      .load_val (csr_data[30:0]),
      .add_q    (state_ff == StPred),
      .sq       (state_ff == StMul),
      .mul_s    (state_ff == StMulS),
      .reduce   (state_ff == StUpd),
      .q_val    (q_ff),
      .r_val    (r_ff),
      .gain     (gain_ff),
      .p_out    (p_w),
      .s_out    (s_w)
   );

   assign rsp_valid      = out_valid_ff;
   assign rsp_pred_lane  = pred_w;
   assign rsp_est_lane   = est_w;
   assign rsp_step_count = cnt_ff;

   // The sequencer never starts while a result waits.
   a_no_start: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(req_valid && req_ready)) else $error("start during hold");
   // Gain never exceeds one.
   a_gain: assert property (@(posedge clock) disable iff (reset)
      div_done |=> gain_ff <= 17'd65536) else $error("gain above one");
endmodule

>>> tb/kalman_tracker_step_test.sv
// Self-checking testbench for kalman_tracker_step: drives measurement vectors,
// register writes and a stalling receiver; predicts every result internally.
// Depends on kts_pkg and the kalman_tracker_step RTL.
`timescale 1ns / 100ps

module kalman_tracker_step_test;

   localparam int Lanes        = kts_pkg::LanesDefault;
   localparam int IdleLimit    = 20000;
   localparam int RandomItems  = 1700;
   localparam int SettleCycles = 80;
   localparam logic [kts_pkg::CsrIdxWidth-1:0] RegUnused = 2'd3;

   typedef logic signed [kts_pkg::DataWidth-1:0] sample_type;

   typedef struct {
      sample_type                     pred [Lanes];
      sample_type                     est [Lanes];
      logic [kts_pkg::CountWidth-1:0] count;
   } track_result_type;

   // Tracker state mirror and pending-result store
   class track_scoreboard_type;
      logic [kts_pkg::RegWidth-1:0]   q_var;
      logic [kts_pkg::RegWidth-1:0]   r_var;
      sample_type                     est_st [Lanes];
      sample_type                     vel_st [Lanes];
      logic [31:0]                    cov;
      logic [kts_pkg::CountWidth-1:0] steps;
      track_result_type               pending [$];
      int                             errors;

      function new();
         q_var  = kts_pkg::QReset;
         r_var  = kts_pkg::RReset;
         for (int i = 0; i < Lanes; i++) begin
            est_st[i] = '0;
            vel_st[i] = '0;
         end
         cov    = 32'(kts_pkg::PInitReset);
         steps  = '0;
         errors = 0;
      endfunction

      function sample_type clamp(input longint v);
         if (v > 64'sd2147483647) return 32'sh7fffffff;
         if (v < -64'sd2147483648) return 32'sh80000000;
         return sample_type'(v);
      endfunction

      function void write_reg(input logic [kts_pkg::CsrIdxWidth-1:0] idx,
                              input logic [31:0] d);
         logic [kts_pkg::RegWidth-1:0] v;
         v = d[kts_pkg::RegWidth-1:0];
         case (idx)
            kts_pkg::RegProcessNoise:     q_var = v;
            kts_pkg::RegMeasurementNoise: r_var = v;
            kts_pkg::RegInitialCov: begin
               cov = 32'(v);
            end
            default: ;
         endcase
      endfunction

      // Note an accepted measurement and queue its expected result
      function void note_measurement(input sample_type z [Lanes]);
         track_result_type r;
         logic [63:0]   s_w;
         logic [31:0]   s;
         logic [63:0]   gain;
         logic [63:0]   red;
         longint        prod;
         longint        corr;
         for (int i = 0; i < Lanes; i++) begin
            r.pred[i] = clamp(longint'(est_st[i]) + longint'(vel_st[i]));
            est_st[i] = r.pred[i];
            vel_st[i] = clamp(longint'(z[i]) - longint'(r.pred[i]));
         end
         s_w = 64'(cov) + 64'(q_var);
         cov = (s_w > 64'hffffffff) ? 32'hffffffff : s_w[31:0];
         s_w = 64'(cov) + 64'(r_var);
         s   = (s_w > 64'hffffffff) ? 32'hffffffff : s_w[31:0];
         gain = (s == 0) ? 64'd0 : ((64'(cov) << 16) / 64'(s));
         for (int i = 0; i < Lanes; i++) begin
            prod = longint'(gain) * longint'(vel_st[i]) + 32768;
            corr = prod >>> 16;
            est_st[i] = clamp(longint'(est_st[i]) + corr);
            r.est[i] = est_st[i];
         end
         red = (gain * gain * 64'(s) + 64'h80000000) >> 32;
         cov = (red >= 64'(cov)) ? 32'd0 : cov - red[31:0];
         steps = steps + 1'b1;
         r.count = steps;
         pending.push_back(r);
      endfunction

      // Compare a transferred result with the oldest expectation
      function void check_result(input sample_type p [Lanes], input sample_type e [Lanes],
                                 input logic [kts_pkg::CountWidth-1:0] c);
         track_result_type x;
         if (pending.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         x = pending.pop_front();
         for (int i = 0; i < Lanes; i++) begin
            if (p[i] !== x.pred[i]) begin
               $error("pred_lane%0d expected %0d actual %0d", i, x.pred[i], p[i]);
               errors++;
            end
            if (e[i] !== x.est[i]) begin
               $error("est_lane%0d expected %0d actual %0d", i, x.est[i], e[i]);
               errors++;
            end
         end
         if (c !== x.count) begin
            $error("step_count expected %0d actual %0d", x.count, c);
            errors++;
         end
      endfunction
   endclass

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   sample_type req_meas_lane [Lanes];
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   sample_type rsp_pred_lane [Lanes];
   sample_type rsp_est_lane [Lanes];
   logic [kts_pkg::CountWidth-1:0]  rsp_step_count;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [kts_pkg::CsrIdxWidth-1:0] csr_index = '0;
   logic [kts_pkg::DataWidth-1:0]   csr_data = '0;

   track_scoreboard_type sb;
   int  idle_cycles = 0;
   int  stall_mode = 0;

   always #6 clock = ~clock;

   kalman_tracker_step #(.LANES(Lanes)) u_dut (
      .clock, .reset,
      .req_valid, .req_ready, .req_meas_lane,
      .rsp_valid, .rsp_ready, .rsp_pred_lane, .rsp_est_lane, .rsp_step_count,
      .csr_valid, .csr_ready, .csr_index, .csr_data
   );

   initial begin
      for (int i = 0; i < Lanes; i++) req_meas_lane[i] = '0;
      sb = new();
   end

   // Check results, count idle cycles and step the receiver stall pattern
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            sb.check_result(rsp_pred_lane, rsp_est_lane, rsp_step_count);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
         case (stall_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ($urandom_range(0, 99) < 5);
         endcase
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (idle_cycles >= IdleLimit) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Drop valid after the transfer and hold it low for one cycle
   task automatic send_meas(input sample_type z [Lanes]);
      req_valid <= 1'b1;
      for (int i = 0; i < Lanes; i++) req_meas_lane[i] <= z[i];
      do @(posedge clock); while (!req_ready);
      sb.note_measurement(z);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_csr(input logic [kts_pkg::CsrIdxWidth-1:0] idx, input logic [31:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, d);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   function automatic sample_type rand_sample(input int mode);
      case (mode)
         0: return sample_type'($urandom);
         1: return sample_type'($signed($urandom_range(0, 2000000)) - 1000000);
         2: return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
         default: return sample_type'($signed($urandom_range(0, 65535)) - 32768);
      endcase
   endfunction

   task automatic random_phase(input int n);
      sample_type z [Lanes];
      int      burst;
      int      mode;
      int      k;
      k = 0;
      while (k < n) begin
         burst = $urandom_range(1, 20);
         mode = $urandom_range(0, 9);
         mode = (mode < 2) ? 0 : (mode < 6) ? 1 : (mode < 7) ? 2 : 3;
         for (int b = 0; b < burst && k < n; b++) begin
            for (int i = 0; i < Lanes; i++) z[i] = rand_sample(mode);
            send_meas(z);
            k++;
         end
         if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 60)) @(posedge clock);
      end
   endtask

   initial begin : stimulus
      sample_type z [Lanes];
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero, alternating signs, per-lane ramp
      for (int i = 0; i < Lanes; i++) z[i] = 32'sh7fffffff;
      send_meas(z);
      send_meas(z);
      for (int i = 0; i < Lanes; i++) z[i] = 32'sh80000000;
      send_meas(z);
      send_meas(z);
      for (int i = 0; i < Lanes; i++) z[i] = (i % 2) ? 32'sh80000000 : 32'sh7fffffff;
      send_meas(z);
      for (int i = 0; i < Lanes; i++) z[i] = '0;
      send_meas(z);
      for (int i = 0; i < Lanes; i++) z[i] = 32'sh00010000 * (i + 1);
      send_meas(z);
      drain();

      // Zero innovation covariance: q, r and p all zero
      write_csr(kts_pkg::RegProcessNoise, 32'h0);
      write_csr(kts_pkg::RegMeasurementNoise, 32'h0);
      write_csr(kts_pkg::RegInitialCov, 32'h0);
      for (int i = 0; i < Lanes; i++) z[i] = 32'sh00050000;
      send_meas(z);
      send_meas(z);
      drain();

      // Saturating covariance, top bit of data dropped, out-of-range index
      write_csr(kts_pkg::RegProcessNoise, 32'hffffffff);
      write_csr(kts_pkg::RegMeasurementNoise, 32'hffffffff);
      write_csr(kts_pkg::RegInitialCov, 32'hffffffff);
      write_csr(RegUnused, 32'h12345678);
      for (int i = 0; i < Lanes; i++) z[i] = 32'sh80000000;
      send_meas(z);
      send_meas(z);
      for (int i = 0; i < Lanes; i++) z[i] = 32'sh7fffffff;
      send_meas(z);
      drain();

      // Random phases with changing noise settings
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(kts_pkg::RegProcessNoise,
                   (ph == 7) ? 32'h7fffffff : $urandom_range(0, 300000));
         write_csr(kts_pkg::RegMeasurementNoise, (ph == 6) ? 32'h0 : $urandom);
         if ($urandom_range(0, 1) != 0)
            write_csr(kts_pkg::RegInitialCov, $urandom_range(0, 2000000));
         random_phase(RandomItems / 8);
         drain();
      end

      // Final settle and verdict
      drain();
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
